FILE: rtl/qtrs_pkg.sv
// Shared types, constants and helpers for the Q-table radius selector.
// No dependencies; every other file in rtl/ imports this package.
package qtrs_pkg;

   // Default table geometry
   localparam int QTRS_NUM_STATES  = 128;
   localparam int QTRS_NUM_ACTIONS = 16;

   // Q2.14 value format
   localparam int                 Q_W   = 16;
   localparam logic signed [15:0] Q_ONE = 16'sh4000;
   localparam logic signed [15:0] Q_MIN = 16'sh8000;

   // Control register port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RADIUS     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STATES_IN_USE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIONS_IN_USE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LEARN_STEP     = 2'd3;

   localparam logic [15:0] RST_MAX_RADIUS     = 16'd8000;
   localparam logic [7:0]  RST_STATES_IN_USE  = 8'd100;
   localparam logic [4:0]  RST_ACTIONS_IN_USE = 5'd10;
   localparam logic [14:0] RST_LEARN_STEP     = 15'd164;

   // Field widths
   localparam int DIST_W   = 18;
   localparam int RADIUS_W = 16;
   localparam int STATES_W = 8;
   localparam int ACTS_W   = 5;
   localparam int STEP_W   = 15;

   // Shared divider geometry
   localparam int DIV_NUM_W = 26;
   localparam int DIV_DEN_W = 17;
   localparam int DIV_Q_W   = 16;
   localparam int DIV_SH_W  = 4;
   localparam int DIV_DSH_W = DIV_DEN_W + DIV_Q_W - 1;

   // Highest quotient bit for each use of the divider
   localparam logic [DIV_SH_W-1:0] DIV_TOP_ROW    = 4'd7;
   localparam logic [DIV_SH_W-1:0] DIV_TOP_RADIUS = 4'd15;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] numer;
      logic [DIV_DEN_W-1:0] denom;
      logic [DIV_SH_W-1:0]  top_bit;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_Q_W-1:0] quot;
   } div_rsp_type;

   // Index width for a count of entries, at least one bit
   function automatic int idx_width(input int count);
      return (count > 1) ? $clog2(count) : 1;
   endfunction

endpackage

FILE: rtl/qtrs_div.sv
// Restoring divider for the Q-table radius selector, one quotient bit per cycle.
// Depends on qtrs_pkg for the request and response types.
module qtrs_div
   import qtrs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_NUM_W-1:0] rem_ff, rem_in;
   logic [DIV_DSH_W-1:0] dsh_ff, dsh_in;
   logic [DIV_SH_W-1:0]  cnt_ff, cnt_in;
   logic [DIV_Q_W-1:0]   quot_ff, quot_in;

   logic [DIV_DSH_W-1:0] rem_wide;
   logic [DIV_DSH_W-1:0] diff;
   logic                 fits;

   // Compare the remainder with the shifted divisor
   always_comb begin
      rem_wide = DIV_DSH_W'(rem_ff);
      fits     = rem_wide >= dsh_ff;
      diff     = rem_wide - dsh_ff;
   end

   // Load on start, then retire one quotient bit per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      if (req.start) begin
         busy_in = 1'b1;
         rem_in  = req.numer;
         dsh_in  = DIV_DSH_W'(req.denom) << req.top_bit;
         cnt_in  = req.top_bit;
         quot_in = '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = DIV_NUM_W'(diff);
         end
         quot_in = {quot_ff[DIV_Q_W-2:0], fits};
         dsh_in  = dsh_ff >> 1;
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      cnt_ff  <= cnt_in;
      quot_ff <= quot_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

endmodule

FILE: rtl/qtrs_store.sv
// Q-value memory for the Q-table radius selector: one write port, one
// registered read port, and a clearing sweep to 1.0 after reset. Uses qtrs_pkg.
module qtrs_store
   import qtrs_pkg::*;
#(
   parameter int NUM_STATES  = QTRS_NUM_STATES,
   parameter int NUM_ACTIONS = QTRS_NUM_ACTIONS
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic [idx_width(NUM_STATES*NUM_ACTIONS)-1:0] rd_addr,
   output logic signed [Q_W-1:0]    rd_data,
   input  logic                     wr_en,
   input  logic [idx_width(NUM_STATES*NUM_ACTIONS)-1:0] wr_addr,
   input  logic signed [Q_W-1:0]    wr_data,
   output logic                     clearing
);

   localparam int DEPTH  = NUM_STATES * NUM_ACTIONS;
   localparam int ADDR_W = idx_width(DEPTH);

   logic signed [Q_W-1:0] mem [DEPTH];
   logic signed [Q_W-1:0] rd_data_ff;

   logic              clear_ff, clear_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic signed [Q_W-1:0] mem_wdata;

   // Sweep every entry once after reset
   always_comb begin
      clear_in    = clear_ff;
      clr_addr_in = clr_addr_ff;
      if (clear_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clear_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff    <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clear_ff    <= clear_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // The sweep owns the write port while it runs
   always_comb begin
      mem_we    = clear_ff | wr_en;
      mem_waddr = clear_ff ? clr_addr_ff : wr_addr;
      mem_wdata = clear_ff ? Q_ONE : wr_data;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clear_ff;

endmodule

FILE: rtl/q_table_radius_selector_top.sv
// Top level of the Q-table radius selector: control registers, sequencer,
// argmax scan and result register. Uses qtrs_pkg, qtrs_div and qtrs_store.
//
// Usage: each request beat carries a command, a distance and a route-found
// flag. The distance picks a table row; the block scans the row's columns in
// use, picks the largest value (lowest column on a tie) and answers with one
// response beat: radius, column, row and the entry value after the step. An
// update command also adds or subtracts learn_step at that entry, capped at
// 1.0 and saturated at the bottom. Control registers are written through
// csr_we / csr_index / csr_wdata; the user must do so only while no request
// is in flight, as the block itself does not enforce it.
// Timing: one request at a time; a new request is taken only once the result
// of the last one has moved to the output register. The time per item is
// set by the shared radix-2 divider, used for the row and then the radius,
// and by the one-column-per-cycle scan of the memory read port; a distance
// at or beyond twice max_radius skips the row division.
// Reset: all NUM_STATES*NUM_ACTIONS entries (2048 by default) are written
// to 1.0 by a sweep during which req_ready stays low.
// Stall: the response sits in an output register; the next request may be
// accepted and worked on, and the block holds its finished result until the
// register frees up.
module q_table_radius_selector_top
   import qtrs_pkg::*;
#(
   parameter int NUM_STATES  = QTRS_NUM_STATES,
   parameter int NUM_ACTIONS = QTRS_NUM_ACTIONS
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_command,
   input  logic [DIST_W-1:0]     req_distance,
   input  logic                  req_route_found,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [RADIUS_W-1:0]   rsp_radius,
   output logic [3:0]            rsp_action_index,
   output logic [6:0]            rsp_state_index,
   output logic signed [Q_W-1:0] rsp_q_value,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ADDR_W = idx_width(NUM_STATES * NUM_ACTIONS);
   localparam int ROW_W  = idx_width(NUM_STATES);
   localparam int COL_W  = idx_width(NUM_ACTIONS);

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b0000_0001,
      ST_IDLE  = 8'b0000_0010,
      ST_BIN   = 8'b0000_0100,
      ST_DIVR  = 8'b0000_1000,
      ST_SCAN  = 8'b0001_0000,
      ST_RAD   = 8'b0010_0000,
      ST_DIVA  = 8'b0100_0000,
      ST_FIN   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // Control registers
   logic [RADIUS_W-1:0] max_radius_ff;
   logic [STATES_W-1:0] states_ff;
   logic [ACTS_W-1:0]   actions_ff;
   logic [STEP_W-1:0]   step_ff;

   // Request held for the item at work
   logic              cmd_ff, cmd_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic              found_ff, found_in;

   // Row and argmax scan
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [COL_W-1:0]      issue_col_ff, issue_col_in;
   logic                  issue_done_ff, issue_done_in;
   logic [COL_W-1:0]      data_col_ff, data_col_in;
   logic                  data_vld_ff, data_vld_in;
   logic [COL_W-1:0]      best_col_ff, best_col_in;
   logic signed [Q_W-1:0] best_val_ff, best_val_in;

   // Response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RADIUS_W-1:0]   rsp_radius_ff, rsp_radius_in;
   logic [3:0]            rsp_action_ff, rsp_action_in;
   logic [6:0]            rsp_state_ff, rsp_state_in;
   logic signed [Q_W-1:0] rsp_q_ff, rsp_q_in;

   // Effective configuration
   logic [RADIUS_W-1:0] radius_eff;
   logic [RADIUS_W:0]   span;
   logic [STATES_W-1:0] states_eff;
   logic [ACTS_W-1:0]   actions_eff;
   logic [STEP_W-1:0]   step_eff;
   logic [COL_W-1:0]    last_col;

   // Entry update
   logic signed [Q_W+1:0] upd_wide;
   logic signed [Q_W+1:0] step_wide;
   logic signed [Q_W+1:0] upd_sum;
   logic signed [Q_W+1:0] upd_diff;
   logic signed [Q_W-1:0] v_new;

   // Submodule links
   div_req_type           div_req;
   div_rsp_type           div_rsp;
   logic [ADDR_W-1:0]     rd_addr;
   logic signed [Q_W-1:0] rd_data;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic                  clearing;
   logic                  req_fire;
   logic                  rsp_free;

   // Write control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_radius_ff <= RST_MAX_RADIUS;
         states_ff     <= RST_STATES_IN_USE;
         actions_ff    <= RST_ACTIONS_IN_USE;
         step_ff       <= RST_LEARN_STEP;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_RADIUS:     max_radius_ff <= csr_wdata[RADIUS_W-1:0];
            CSR_STATES_IN_USE:  states_ff     <= csr_wdata[STATES_W-1:0];
            CSR_ACTIONS_IN_USE: actions_ff    <= csr_wdata[ACTS_W-1:0];
            CSR_LEARN_STEP:     step_ff       <= csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp configuration to usable ranges
   always_comb begin
      radius_eff = (max_radius_ff == '0) ? RADIUS_W'(1) : max_radius_ff;
      span       = {radius_eff, 1'b0};
      if (states_ff == '0) begin
         states_eff = STATES_W'(1);
      end else if (32'(states_ff) > NUM_STATES) begin
         states_eff = STATES_W'(NUM_STATES);
      end else begin
         states_eff = states_ff;
      end
      if (actions_ff == '0) begin
         actions_eff = ACTS_W'(1);
      end else if (32'(actions_ff) > NUM_ACTIONS) begin
         actions_eff = ACTS_W'(NUM_ACTIONS);
      end else begin
         actions_eff = actions_ff;
      end
      step_eff = (step_ff > STEP_W'(Q_ONE)) ? STEP_W'(Q_ONE) : step_ff;
      last_col = COL_W'(actions_eff - 1'b1);
   end

   // Step the chosen entry with saturation
   always_comb begin
      upd_wide  = (Q_W+2)'(best_val_ff);
      step_wide = (Q_W+2)'(step_eff);
      upd_sum   = upd_wide + step_wide;
      upd_diff  = upd_wide - step_wide;
      v_new     = best_val_ff;
      if (cmd_ff) begin
         if (found_ff) begin
            v_new = (upd_sum > (Q_W+2)'(Q_ONE)) ? Q_ONE : Q_W'(upd_sum);
         end else begin
            v_new = (upd_diff < (Q_W+2)'(Q_MIN)) ? Q_MIN : Q_W'(upd_diff);
         end
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign rsp_free  = ~rsp_valid_ff | rsp_ready;

   // Read the column being issued; write back the chosen entry
   assign rd_addr = ADDR_W'(32'(row_ff) * NUM_ACTIONS) + ADDR_W'(issue_col_ff);
   assign wr_addr = ADDR_W'(32'(row_ff) * NUM_ACTIONS) + ADDR_W'(best_col_ff);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      dist_in       = dist_ff;
      found_in      = found_ff;
      row_in        = row_ff;
      issue_col_in  = issue_col_ff;
      issue_done_in = issue_done_ff;
      data_col_in   = data_col_ff;
      data_vld_in   = 1'b0;
      best_col_in   = best_col_ff;
      best_val_in   = best_val_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_radius_in = rsp_radius_ff;
      rsp_action_in = rsp_action_ff;
      rsp_state_in  = rsp_state_ff;
      rsp_q_in      = rsp_q_ff;
      wr_en         = 1'b0;
      div_req       = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            if (!clearing) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in   = req_command;
               dist_in  = req_distance;
               found_in = req_route_found;
               state_in = ST_BIN;
            end
         end
         ST_BIN: begin
            issue_col_in  = '0;
            issue_done_in = 1'b0;
            if (dist_ff >= DIST_W'(span)) begin
               row_in   = ROW_W'(states_eff - 1'b1);
               state_in = ST_SCAN;
            end else begin
               div_req.start   = 1'b1;
               div_req.numer   = DIV_NUM_W'(dist_ff) * DIV_NUM_W'(states_eff);
               div_req.denom   = DIV_DEN_W'(span);
               div_req.top_bit = DIV_TOP_ROW;
               state_in        = ST_DIVR;
            end
         end
         ST_DIVR: begin
            if (div_rsp.done) begin
               row_in   = ROW_W'(div_rsp.quot);
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Issue one column per cycle
            if (!issue_done_ff) begin
               data_vld_in = 1'b1;
               data_col_in = issue_col_ff;
               if (issue_col_ff == last_col) begin
                  issue_done_in = 1'b1;
               end else begin
                  issue_col_in = issue_col_ff + 1'b1;
               end
            end
            // Keep the first strict maximum
            if (data_vld_ff) begin
               if (data_col_ff == '0 || rd_data > best_val_ff) begin
                  best_col_in = data_col_ff;
                  best_val_in = rd_data;
               end
               if (data_col_ff == last_col) begin
                  state_in = ST_RAD;
               end
            end
         end
         ST_RAD: begin
            div_req.start   = 1'b1;
            div_req.numer   = (DIV_NUM_W'(best_col_ff) + 1'b1) * DIV_NUM_W'(radius_eff);
            div_req.denom   = DIV_DEN_W'(actions_eff);
            div_req.top_bit = DIV_TOP_RADIUS;
            state_in        = ST_DIVA;
         end
         ST_DIVA: begin
            if (div_rsp.done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // Hold until the response register frees up; the quotient stays put
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_radius_in = div_rsp.quot;
               rsp_action_in = 4'(best_col_ff);
               rsp_state_in  = 7'(row_ff);
               rsp_q_in      = v_new;
               wr_en         = cmd_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         rsp_valid_ff  <= 1'b0;
         data_vld_ff   <= 1'b0;
         issue_done_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         data_vld_ff   <= data_vld_in;
         issue_done_ff <= issue_done_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      dist_ff       <= dist_in;
      found_ff      <= found_in;
      row_ff        <= row_in;
      issue_col_ff  <= issue_col_in;
      data_col_ff   <= data_col_in;
      best_col_ff   <= best_col_in;
      best_val_ff   <= best_val_in;
      rsp_radius_ff <= rsp_radius_in;
      rsp_action_ff <= rsp_action_in;
      rsp_state_ff  <= rsp_state_in;
      rsp_q_ff      <= rsp_q_in;
   end

   qtrs_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Write-back happens in the last state, so no read of the next item overlaps it
   qtrs_store #(
      .NUM_STATES  (NUM_STATES),
      .NUM_ACTIONS (NUM_ACTIONS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (v_new),
      .clearing (clearing)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_radius       = rsp_radius_ff;
   assign rsp_action_index = rsp_action_ff;
   assign rsp_state_index  = rsp_state_ff;
   assign rsp_q_value      = rsp_q_ff;

endmodule

FILE: rtl/qtrs_chk.sv
// Port-level checker for the Q-table radius selector, bound to the top level.
// Depends on qtrs_pkg for widths and the Q2.14 constants.
module qtrs_chk
   import qtrs_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  req_command,
   input logic [DIST_W-1:0]     req_distance,
   input logic                  req_route_found,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [RADIUS_W-1:0]   rsp_radius,
   input logic [3:0]            rsp_action_index,
   input logic [6:0]            rsp_state_index,
   input logic signed [Q_W-1:0] rsp_q_value
);

   // Reset starts the clearing sweep, so no request is taken right after it
   a_reset_blocks_req: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("req_ready high right after reset");

   // One item at a time: no request beat on the cycle after an accepted one
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while another is in flight");

   // A waiting request beat holds its payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_ready) |=> (req_valid && $stable(req_command)
         && $stable(req_distance) && $stable(req_route_found)))
      else $error("waiting request changed");

   // A stalled response beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_radius)
         && $stable(rsp_action_index) && $stable(rsp_state_index)
         && $stable(rsp_q_value)))
      else $error("stalled response changed");

   // Entry values never rise above 1.0
   a_q_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_q_value <= Q_ONE))
      else $error("q_value above 1.0");

endmodule

bind q_table_radius_selector_top qtrs_chk u_qtrs_chk (.*);
